### design/stc_pkg.sv
package stc_pkg;

   // default longest string or atom kept, in bytes
   localparam int MAX_TOKEN_LENGTH_DEF = 512;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int DEPTH_W = 16;
   localparam int LEN_W   = 10;
   localparam int KIND_W  = 3;

   // result queue depth (room for one two-word item behind a waiting word)
   localparam int QDEPTH = 3;

   // characters with a meaning of their own
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_LF    = 8'd10;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_OPEN    = 3'd0,
      KIND_CLOSE   = 3'd1,
      KIND_STRING  = 3'd2,
      KIND_INTEGER = 3'd3,
      KIND_FLOAT   = 3'd4,
      KIND_SYMBOL  = 3'd5,
      KIND_BYTE    = 3'd6
   } kind_type;

   // integer matcher states
   typedef enum logic [1:0] {
      I_START = 2'd0,
      I_SIGN  = 2'd1,
      I_DIG   = 2'd2,
      I_DEAD  = 2'd3
   } int_state_type;

   // float matcher states (strtod grammar)
   typedef enum logic [4:0] {
      F_START, F_SIGN, F_ZERO, F_DINT, F_DOTNODIG, F_DFRAC, F_EXP, F_EXPSIGN,
      F_EXPDIG, F_HEX0, F_HEXINT, F_HEXDOTNODIG, F_HEXFRAC, F_PEXP, F_PEXPSIGN,
      F_PEXPDIG, F_I, F_IN, F_INF, F_INFI, F_INFIN, F_INFINI, F_INFINIT,
      F_INFINITY, F_N, F_NA, F_NAN, F_DEAD
   } flt_state_type;

   // one result word
   typedef struct packed {
      kind_type                   kind;
      logic signed [DEPTH_W-1:0]  depth;
      logic [BYTE_W-1:0]          content_byte;
      logic [LEN_W-1:0]           token_length;
      logic                       last;
   } rsp_type;

   // queue status toward the input side
   typedef struct packed {
      logic [1:0] count;
      logic       space2;
   } q_status_type;

   // float matcher ends in an accepting state
   function automatic logic float_accepts(flt_state_type s);
      return s == F_ZERO || s == F_DINT || s == F_DFRAC || s == F_EXPDIG ||
             s == F_HEXINT || s == F_HEXFRAC || s == F_PEXPDIG ||
             s == F_INF || s == F_INFINITY || s == F_NAN;
   endfunction

   // c whitespace
   function automatic logic is_ws(logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
   endfunction

endpackage

### design/stc_class.sv
module stc_class (
   input  logic [7:0]             data_byte,
   input  stc_pkg::int_state_type int_s,
   input  stc_pkg::flt_state_type flt_s,
   output stc_pkg::int_state_type int_nx,
   output stc_pkg::flt_state_type flt_nx
);
   import stc_pkg::*;

   logic [7:0]    b;
   logic          d;
   logic          h;
   logic          sg;
   flt_state_type start_nx;
   flt_state_type dint_nx;

   // lower-case the byte and class it
   always_comb begin
      b  = (data_byte >= 8'h41 && data_byte <= 8'h5a) ? (data_byte | 8'h20) : data_byte;
      d  = b >= 8'h30 && b <= 8'h39;
      h  = d || (b >= 8'h61 && b <= 8'h66);
      sg = b == 8'h2b || b == 8'h2d;
   end

   // integer matcher
   always_comb begin
      priority if (int_s == I_START && sg) begin
         int_nx = I_SIGN;
      end else if (int_s != I_DEAD && d) begin
         int_nx = I_DIG;
      end else begin
         int_nx = I_DEAD;
      end
   end

   // shared arms of the float matcher
   always_comb begin
      priority if (b == 8'h30) start_nx = F_ZERO;
      else if (d)             start_nx = F_DINT;
      else if (b == 8'h2e)    start_nx = F_DOTNODIG;
      else if (b == 8'h69)    start_nx = F_I;
      else if (b == 8'h6e)    start_nx = F_N;
      else                    start_nx = F_DEAD;

      priority if (d)         dint_nx = F_DINT;
      else if (b == 8'h2e)    dint_nx = F_DFRAC;
      else if (b == 8'h65)    dint_nx = F_EXP;
      else                    dint_nx = F_DEAD;
   end

   // float matcher
   always_comb begin
      unique case (flt_s)
         F_START:       flt_nx = sg ? F_SIGN : start_nx;
         F_SIGN:        flt_nx = start_nx;
         F_ZERO:        flt_nx = (b == 8'h78) ? F_HEX0 : dint_nx;
         F_DINT:        flt_nx = dint_nx;
         F_DOTNODIG:    flt_nx = d ? F_DFRAC : F_DEAD;
         F_DFRAC:       flt_nx = d ? F_DFRAC : (b == 8'h65) ? F_EXP : F_DEAD;
         F_EXP:         flt_nx = sg ? F_EXPSIGN : d ? F_EXPDIG : F_DEAD;
         F_EXPSIGN,
         F_EXPDIG:      flt_nx = d ? F_EXPDIG : F_DEAD;
         F_HEX0:        flt_nx = h ? F_HEXINT : (b == 8'h2e) ? F_HEXDOTNODIG : F_DEAD;
         F_HEXINT:      flt_nx = h ? F_HEXINT : (b == 8'h2e) ? F_HEXFRAC :
                                 (b == 8'h70) ? F_PEXP : F_DEAD;
         F_HEXDOTNODIG: flt_nx = h ? F_HEXFRAC : F_DEAD;
         F_HEXFRAC:     flt_nx = h ? F_HEXFRAC : (b == 8'h70) ? F_PEXP : F_DEAD;
         F_PEXP:        flt_nx = sg ? F_PEXPSIGN : d ? F_PEXPDIG : F_DEAD;
         F_PEXPSIGN,
         F_PEXPDIG:     flt_nx = d ? F_PEXPDIG : F_DEAD;
         F_I:           flt_nx = (b == 8'h6e) ? F_IN : F_DEAD;
         F_IN:          flt_nx = (b == 8'h66) ? F_INF : F_DEAD;
         F_INF:         flt_nx = (b == 8'h69) ? F_INFI : F_DEAD;
         F_INFI:        flt_nx = (b == 8'h6e) ? F_INFIN : F_DEAD;
         F_INFIN:       flt_nx = (b == 8'h69) ? F_INFINI : F_DEAD;
         F_INFINI:      flt_nx = (b == 8'h74) ? F_INFINIT : F_DEAD;
         F_INFINIT:     flt_nx = (b == 8'h79) ? F_INFINITY : F_DEAD;
         F_N:           flt_nx = (b == 8'h61) ? F_NA : F_DEAD;
         F_NA:          flt_nx = (b == 8'h6e) ? F_NAN : F_DEAD;
         default:       flt_nx = F_DEAD;
      endcase
   end

endmodule

### design/stc_scan.sv
module stc_scan #(
   parameter int MAX_TOKEN_LENGTH = stc_pkg::MAX_TOKEN_LENGTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic [7:0]      data_byte,
   input  logic            end_of_input,
   output stc_pkg::rsp_type res0,
   output stc_pkg::rsp_type res1,
   output logic [1:0]      res_count
);
   import stc_pkg::*;

   localparam int CountWidth = $clog2(MAX_TOKEN_LENGTH + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_TOKEN_LENGTH);

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_ATOM   = 2'd1,
      MODE_STRING = 2'd2
   } mode_type;

   mode_type                  mode_ff, mode_in;
   logic signed [DEPTH_W-1:0] depth_ff, depth_in;
   logic [CountWidth-1:0]     count_ff, count_in;
   int_state_type             int_ff, int_in;
   flt_state_type             flt_ff, flt_in;

   int_state_type             cls_int_s, cls_int_nx;
   flt_state_type             cls_flt_s, cls_flt_nx;

   logic                      ws, is_open, is_close, is_quote, term, room;
   logic                      cont_atom, do_idle, new_atom, fin_atom, lead_valid;
   logic                      idle_valid;
   rsp_type                   atom_tok, string_tok, byte_tok, lead, idle_res;

   // byte classes and the decisions for this word
   always_comb begin
      ws        = is_ws(data_byte);
      is_open   = data_byte == CHAR_OPEN;
      is_close  = data_byte == CHAR_CLOSE;
      is_quote  = data_byte == CHAR_QUOTE;
      term      = ws || is_open || is_close;
      room      = count_ff < CountMax;
      cont_atom = !end_of_input && mode_ff == MODE_ATOM && !term && room;
      fin_atom  = mode_ff == MODE_ATOM && (end_of_input || !cont_atom);
      do_idle   = !end_of_input && (mode_ff == MODE_IDLE || fin_atom);
      new_atom  = do_idle && !is_open && !is_close && !is_quote && !ws;
   end

   // matchers start over on the first byte of an atom
   assign cls_int_s = new_atom ? I_START : int_ff;
   assign cls_flt_s = new_atom ? F_START : flt_ff;

   stc_class u_class (
      .data_byte (data_byte),
      .int_s     (cls_int_s),
      .flt_s     (cls_flt_s),
      .int_nx    (cls_int_nx),
      .flt_nx    (cls_flt_nx)
   );

   // token words
   always_comb begin
      atom_tok              = '0;
      atom_tok.kind         = (int_ff == I_DIG) ? KIND_INTEGER :
                              float_accepts(flt_ff) ? KIND_FLOAT : KIND_SYMBOL;
      atom_tok.token_length = LEN_W'(count_ff);
      string_tok              = '0;
      string_tok.kind         = KIND_STRING;
      string_tok.token_length = LEN_W'(count_ff);
      byte_tok              = '0;
      byte_tok.kind         = KIND_BYTE;
      byte_tok.content_byte = data_byte;
   end

   // results and next state
   always_comb begin
      mode_in    = mode_ff;
      depth_in   = depth_ff;
      count_in   = count_ff;
      int_in     = int_ff;
      flt_in     = flt_ff;
      lead       = '0;
      lead_valid = 1'b0;
      idle_res   = '0;
      idle_valid = 1'b0;

      // word while inside a token or at end of input
      if (end_of_input) begin
         mode_in = MODE_IDLE;
         if (mode_ff == MODE_ATOM) begin
            lead       = atom_tok;
            lead_valid = 1'b1;
         end else if (mode_ff == MODE_STRING) begin
            lead       = string_tok;
            lead_valid = 1'b1;
         end
      end else if (mode_ff == MODE_STRING) begin
         lead_valid = 1'b1;
         if (!is_quote && room) begin
            count_in = count_ff + 1'b1;
            lead     = byte_tok;
         end else begin
            lead    = string_tok;
            mode_in = MODE_IDLE;
         end
      end else if (cont_atom) begin
         count_in   = count_ff + 1'b1;
         int_in     = cls_int_nx;
         flt_in     = cls_flt_nx;
         lead       = byte_tok;
         lead_valid = 1'b1;
      end else if (fin_atom) begin
         lead       = atom_tok;
         lead_valid = 1'b1;
         mode_in    = MODE_IDLE;
      end

      // byte seen between tokens
      if (do_idle) begin
         if (is_open) begin
            if (depth_ff != 16'sh7fff) depth_in = depth_ff + 16'sd1;
            idle_res.kind  = KIND_OPEN;
            idle_res.depth = depth_in;
            idle_valid     = 1'b1;
         end else if (is_close) begin
            if (depth_ff != -16'sh8000) depth_in = depth_ff - 16'sd1;
            idle_res.kind  = KIND_CLOSE;
            idle_res.depth = depth_in;
            idle_valid     = 1'b1;
         end else if (is_quote) begin
            mode_in  = MODE_STRING;
            count_in = '0;
         end else if (new_atom) begin
            mode_in    = MODE_ATOM;
            count_in   = CountWidth'(1);
            int_in     = cls_int_nx;
            flt_in     = cls_flt_nx;
            idle_res   = byte_tok;
            idle_valid = 1'b1;
         end
      end

      // pack into up to two words, mark the final one
      res0      = lead_valid ? lead : idle_res;
      res1      = idle_res;
      res_count = {1'b0, lead_valid} + {1'b0, idle_valid};
      if (lead_valid && idle_valid) begin
         res1.last = 1'b1;
      end else begin
         res0.last = 1'b1;
      end
   end

   // tokenizer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         depth_ff <= '0;
         count_ff <= '0;
         int_ff   <= I_START;
         flt_ff   <= F_START;
      end else if (advance) begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
         count_ff <= count_in;
         int_ff   <= int_in;
         flt_ff   <= flt_in;
      end
   end

endmodule

### design/stc_queue.sv
module stc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  stc_pkg::rsp_type      push0,
   input  stc_pkg::rsp_type      push1,
   input  logic                  pop_ready,
   output stc_pkg::rsp_type      head,
   output stc_pkg::q_status_type status
);
   import stc_pkg::*;

   rsp_type    entry_ff [QDEPTH];
   rsp_type    entry_in [QDEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] base;

   // pop the head, then append behind what remains
   always_comb begin
      pop           = (cnt_ff != 2'd0) && pop_ready;
      base          = cnt_ff - {1'b0, pop};
      status.count  = cnt_ff;
      status.space2 = base <= 2'd1;
      cnt_in        = base + push_count;
      for (int i = 0; i < QDEPTH; i++) begin
         if (pop && i < QDEPTH - 1) entry_in[i] = entry_ff[i+1];
         else                       entry_in[i] = entry_ff[i];
         if (push_count != 2'd0 && 2'(i) == base)        entry_in[i] = push0;
         if (push_count == 2'd2 && 2'(i) == base + 2'd1) entry_in[i] = push1;
      end
   end

   assign head = entry_ff[0];

   // word storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

### design/sexpr_token_classifier.sv
// channel  dir  tdata                                     tuser             tlast
// req_     in   [7:0] data_byte                           [0] end_of_input  -
// rsp_     out  [15:0] depth, [23:16] content_byte,       [2:0] kind        last
//               [33:24] token_length, rest zero
//
// One byte per cycle when the queue has room: a byte is registered, tokenized by
// the scan logic and its zero, one or two result words go into a three-word queue.
// Sustained rate is one byte per cycle while each byte gives at most one word and
// rsp_tready stays high; a byte that gives two words sends them as two rsp_ transfers.
// Reset clears tokenizer state, the input register valid and the queue count.
// A stalled rsp_ side backs up into the queue and then into req_tready.
module sexpr_token_classifier #(
   parameter int MAX_TOKEN_LENGTH = stc_pkg::MAX_TOKEN_LENGTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic [0:0]  req_tuser,    // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [15:0] depth, [23:16] content_byte, [33:24] token_length
   output logic [2:0]  rsp_tuser,    // [2:0] kind
   output logic        rsp_tlast     // last
);
   import stc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_eoi_ff;
   logic         advance;
   rsp_type      res0, res1, head;
   logic [1:0]   res_count;
   q_status_type q_status;

   // input register moves on when the queue has room for two words
   assign advance     = in_valid_ff && q_status.space2;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // input word payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eoi_ff  <= req_tuser[0];
      end
   end

   stc_scan #(
      .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .data_byte    (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .res0         (res0),
      .res1         (res1),
      .res_count    (res_count)
   );

   stc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (advance ? res_count : 2'd0),
      .push0      (res0),
      .push1      (res1),
      .pop_ready  (rsp_tready),
      .head       (head),
      .status     (q_status)
   );

   // result word packing
   assign rsp_tvalid = q_status.count != 2'd0;
   assign rsp_tdata  = {6'd0, head.token_length, head.content_byte, head.depth};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      q_status.count <= 2'(QDEPTH))
      else $error("result queue overfilled");

   // a byte is only taken when two words fit behind the drain
   assert property (@(posedge clock) disable iff (reset)
      advance |=> q_status.count <= 2'(QDEPTH))
      else $error("queue count out of range after push");

   // the second word of a pair is already queued when the first leaves
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("first word of a pair left without its partner");

   // a held input word blocks new input
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !q_status.space2) |-> !req_tready)
      else $error("input accepted while scan stage stalled");

endmodule
